[sv/assert_macros.svh]
// Assertion macros shared by the allow-list RTL.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define CTAL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ctal assertion failed");

// The condition must never be true at a rising clock edge outside reset.
`define CTAL_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ctal forbidden condition seen");

`endif

[sv/ctal_pkg.sv]
// Package for the compacting tag allow-list: payload structs, op and status codes.
// No dependencies; used by ctal_cell, compacting_tag_allow_list_core, ctal_checker and the testbench.
`timescale 1ns / 1ps

package ctal_pkg;

    localparam int CTAL_DEPTH = 32;
    localparam int TAG_W      = 32;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_DEL_VAL  = 3'd1;
    localparam logic [2:0] OP_DEL_SLOT = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_LOOKUP   = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_INVALID   = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_DUPLICATE = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [TAG_W-1:0] tag_code;
        logic [4:0]       slot_number;
    } req_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot_result;
        logic [5:0] entry_count;
    } rsp_item_t;

    // Update command broadcast to every cell in the apply cycle.
    typedef struct packed {
        logic clear;
        logic shift;
        logic write;
    } cell_act_t;

endpackage

[sv/ctal_cell.sv]
// One slot of the allow-list table: holds a tag, compares it with the search code
// and takes its upper neighbor's tag when an entry at or below it is removed. Uses ctal_pkg.
`timescale 1ns / 1ps

module ctal_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctal_pkg::cell_act_t       act,
    input  logic [IDX_W-1:0]          pos,
    input  logic [ctal_pkg::TAG_W-1:0] code,
    input  logic [ctal_pkg::TAG_W-1:0] upper,
    output logic [ctal_pkg::TAG_W-1:0] entry,
    output logic                      match
);
    import ctal_pkg::*;

    logic [TAG_W-1:0] entry_reg;
    logic [TAG_W-1:0] entry_next;
    logic             match_reg;
    logic             at_or_above;
    logic             at_pos;

    assign at_or_above = (IDX_W'(INDEX) >= pos);
    assign at_pos      = (IDX_W'(INDEX) == pos);

    always_comb
    begin
        entry_next = entry_reg;
        if (act.clear)
        begin
            entry_next = '0;
        end
        else if (act.shift && at_or_above)
        begin
            entry_next = upper;
        end
        else if (act.write && at_pos)
        begin
            entry_next = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            match_reg <= (entry_reg == code);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

[sv/compacting_tag_allow_list_core.sv]
// Compacting tag allow-list: a row of table cells and the sequencer that drives them.
// Depends on ctal_pkg, ctal_cell and assert_macros.svh.
`timescale 1ns / 1ps

// After its transfer a request passes through the compare step, in which every cell
// checks its tag against the code, the encode step, which finds the hit slot from the
// cells' match flags, and the apply step, which changes the row while the result loads
// into the output register. One request is in flight at a time and the next request
// can transfer in the cycle after the previous result has loaded; a stalled result
// holds the block in its apply step. Stored tags stay packed in slots 0 to
// entry_count-1 in insertion order; removal shifts every cell above the gap down by
// one, all at once in the apply step. The table is empty right after reset.
module compacting_tag_allow_list_core #(
    parameter int TABLE_DEPTH = ctal_pkg::CTAL_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ctal_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ctal_pkg::rsp_item_t rsp
);
    import ctal_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SXW   = (IDX_W > 5) ? IDX_W : 5;
    localparam int CXW   = (CNT_W > 6) ? CNT_W : 6;
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_ENC   = 4'b0100,
        ST_APPLY = 4'b1000
    } ctal_state_t;

    ctal_state_t      state_reg, state_next;
    req_item_t        req_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             found_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_item_t        rsp_reg, rsp_next;

    logic [TAG_W-1:0] entry_vec [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] occ_vec;
    logic [TABLE_DEPTH-1:0] expect_occ;

    cell_act_t        act;
    logic [IDX_W-1:0] act_pos;
    logic             code_zero;
    logic             hit_any;
    logic [IDX_W-1:0] hit_or;
    logic             apply_go;
    logic [SXW-1:0]   idx_ext;
    logic [CMP_W-1:0] cnt_slot;
    logic [CXW-1:0]   cnt_ext;
    logic [4:0]       slot_out;
    logic [2:0]       status_out;

    // Row of cells; the top cell takes in zero when the row shifts down.
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++)
    begin : g_cell
        logic [TAG_W-1:0] upper;
        if (gi == TABLE_DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = entry_vec[gi + 1];
        end

        ctal_cell #(
            .INDEX (gi),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .act   (act),
            .pos   (act_pos),
            .code  (req_reg.tag_code),
            .upper (upper),
            .entry (entry_vec[gi]),
            .match (match_vec[gi])
        );

        assign occ_vec[gi] = (entry_vec[gi] != '0);
    end

    assign code_zero = (req_reg.tag_code == '0);

    // Stored nonzero tags are unique, so at most one cell matches a nonzero code.
    always_comb
    begin
        hit_any = 1'b0;
        hit_or  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                hit_any = 1'b1;
                hit_or  = hit_or | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            expect_occ[i] = (i < int'(count_reg));
        end
    end

    assign apply_go = (state_reg == ST_APPLY) && (!rsp_valid_reg || rsp_ready);
    assign idx_ext  = SXW'(idx_reg);
    assign cnt_slot = CMP_W'(count_reg);

    always_comb
    begin
        act        = '0;
        act_pos    = '0;
        count_next = count_reg;
        status_out = STAT_OK;
        slot_out   = '0;
        case (req_reg.op)
            OP_ADD:
            begin
                if (code_zero)
                begin
                    status_out = STAT_INVALID;
                end
                else if (count_reg == CNT_W'(TABLE_DEPTH))
                begin
                    status_out = STAT_FULL;
                end
                else if (found_reg)
                begin
                    status_out = STAT_DUPLICATE;
                end
                else
                begin
                    act.write  = 1'b1;
                    act_pos    = count_reg[IDX_W-1:0];
                    slot_out   = cnt_slot[4:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DEL_VAL:
            begin
                if (found_reg)
                begin
                    slot_out = idx_ext[4:0];
                    // A zero code only names the first empty slot; nothing moves.
                    if (!code_zero)
                    begin
                        act.shift  = 1'b1;
                        act_pos    = idx_reg;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    status_out = STAT_NOT_FOUND;
                end
            end
            OP_DEL_SLOT:
            begin
                slot_out = req_reg.slot_number;
                if (CMP_W'(req_reg.slot_number) < CMP_W'(count_reg))
                begin
                    act.shift  = 1'b1;
                    act_pos    = IDX_W'(req_reg.slot_number);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                act.clear  = 1'b1;
                count_next = '0;
            end
            OP_LOOKUP:
            begin
                if (found_reg)
                begin
                    slot_out = idx_ext[4:0];
                end
                else
                begin
                    status_out = STAT_NOT_FOUND;
                end
            end
            default:
            begin
                status_out = STAT_OK;
            end
        endcase
        if (!apply_go)
        begin
            act        = '0;
            count_next = count_reg;
        end
    end

    assign cnt_ext = CXW'(count_next);

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg;
        if (apply_go)
        begin
            rsp_next.status      = status_out;
            rsp_next.slot_result = slot_out;
            rsp_next.entry_count = cnt_ext[5:0];
            rsp_valid_next       = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (state_reg == ST_ENC)
        begin
            // A zero code matches the empty slots, the first of which is slot count.
            if (code_zero)
            begin
                found_reg <= (count_reg < CNT_W'(TABLE_DEPTH));
                idx_reg   <= count_reg[IDX_W-1:0];
            end
            else
            begin
                found_reg <= hit_any;
                idx_reg   <= hit_or;
            end
        end
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `CTAL_NEVER(a_count_bound, count_reg > CNT_W'(TABLE_DEPTH))
    `CTAL_ASSERT(a_packed_row, (state_reg == ST_CMP) |-> (occ_vec == expect_occ))
    `CTAL_ASSERT(a_single_hit, (state_reg == ST_ENC && !code_zero) |-> $onehot0(match_vec))
    `CTAL_ASSERT(a_rsp_from_apply, $rose(rsp_valid_reg) |-> $past(state_reg == ST_APPLY))
    `CTAL_ASSERT(a_one_in_flight, (req_valid && req_ready) |=> !req_ready)

endmodule

[test/ctal_checker.sv]
// Scoreboard for the compacting tag allow-list: watches both channels and checks every result.
// Keeps its own copy of the tag table. Depends on ctal_pkg only.
`timescale 1ns / 1ps

module ctal_checker
    import ctal_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_item_t rsp,
    output int        mismatch_count,
    output int        pending_count,
    output int        results_checked,
    output int        full_reports
);

    logic [TAG_W-1:0] tag_row [CTAL_DEPTH];
    int               tag_total;
    rsp_item_t        awaited_rsp [$];

    // First slot holding code; an empty slot matches code zero.
    function automatic int find_tag(logic [TAG_W-1:0] code);
        for (int i = 0; i < CTAL_DEPTH; i++)
        begin
            if (tag_row[i] == code)
                return i;
        end
        return CTAL_DEPTH;
    endfunction

    function automatic rsp_item_t apply_table_op(req_item_t item);
        rsp_item_t        res;
        logic [2:0]       st;
        int               slot;
        int               idx;
        int               w;
        logic [TAG_W-1:0] v;
        st   = STAT_OK;
        slot = 0;
        case (item.op)
            OP_ADD:
            begin
                if (item.tag_code == '0)
                    st = STAT_INVALID;
                else if (tag_total >= CTAL_DEPTH)
                    st = STAT_FULL;
                else if (find_tag(item.tag_code) < CTAL_DEPTH)
                    st = STAT_DUPLICATE;
                else
                begin
                    slot = tag_total;
                    tag_row[slot] = item.tag_code;
                end
            end
            OP_DEL_VAL:
            begin
                idx = find_tag(item.tag_code);
                if (idx < CTAL_DEPTH)
                begin
                    tag_row[idx] = '0;
                    slot = idx;
                end
                else
                    st = STAT_NOT_FOUND;
            end
            OP_DEL_SLOT:
            begin
                if (int'(item.slot_number) < CTAL_DEPTH)
                    tag_row[item.slot_number] = '0;
                slot = item.slot_number;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CTAL_DEPTH; i++)
                    tag_row[i] = '0;
            end
            OP_LOOKUP:
            begin
                idx = find_tag(item.tag_code);
                if (idx < CTAL_DEPTH)
                    slot = idx;
                else
                    st = STAT_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        // Stable compaction toward slot 0.
        w = 0;
        for (int i = 0; i < CTAL_DEPTH; i++)
        begin
            v = tag_row[i];
            if (v != '0)
            begin
                tag_row[i] = '0;
                tag_row[w] = v;
                w++;
            end
        end
        tag_total = w;
        res.status      = st;
        res.slot_result = slot[4:0];
        res.entry_count = tag_total[5:0];
        return res;
    endfunction

    initial
    begin
        for (int i = 0; i < CTAL_DEPTH; i++)
            tag_row[i] = '0;
        tag_total       = 0;
        mismatch_count  = 0;
        pending_count   = 0;
        results_checked = 0;
        full_reports    = 0;
    end

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CTAL_DEPTH; i++)
                tag_row[i] = '0;
            tag_total = 0;
            awaited_rsp.delete();
        end
        else
        begin
            // The result side goes first so that a transfer on both channels in one
            // cycle compares against the older request.
            if (rsp_valid && rsp_ready)
            begin
                results_checked++;
                if (awaited_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: status %0d slot %0d count %0d",
                                 rsp.status, rsp.slot_result, rsp.entry_count);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.slot_result !== want.slot_result
                        || rsp.entry_count !== want.entry_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected status %0d slot %0d count %0d, got status %0d slot %0d count %0d",
                                     want.status, want.slot_result, want.entry_count,
                                     rsp.status, rsp.slot_result, rsp.entry_count);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                want = apply_table_op(req);
                if (want.status == STAT_FULL || tag_total == CTAL_DEPTH)
                    full_reports++;
                awaited_rsp.push_back(want);
            end
        end
        pending_count = awaited_rsp.size();
    end

endmodule

[test/testbench.sv]
// Top of the allow-list testbench: clock, reset, request and result traffic, verdict.
// Depends on ctal_pkg, compacting_tag_allow_list_core and ctal_checker.
`timescale 1ns / 1ps

module testbench;
    import ctal_pkg::*;

    localparam int RANDOM_ITEMS  = 400;
    localparam int SEGMENT_LEN   = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEG_FILL      = 0;
    localparam int SEG_MIXED     = 1;
    localparam int SEG_DRAIN     = 2;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    int mismatch_count;
    int pending_count;
    int results_checked;
    int full_reports;

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    int          requests_sent;
    int          directed_count;
    logic [31:0] added_codes [$];
    req_item_t   directed_reqs [$];

    compacting_tag_allow_list_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ctal_checker scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .results_checked (results_checked),
        .full_reports    (full_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

    function automatic req_item_t make_req(logic [2:0] op, logic [31:0] code,
                                           logic [4:0] slot);
        req_item_t r;
        r.op          = op;
        r.tag_code    = code;
        r.slot_number = slot;
        return r;
    endfunction

    // Codes for delete and lookup mostly come from earlier adds so they hit.
    function automatic logic [31:0] pick_known_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 75 && added_codes.size() > 0)
            return added_codes[$urandom_range(0, added_codes.size() - 1)];
        return $urandom;
    endfunction

    function automatic req_item_t random_req(int seg);
        req_item_t r;
        int        pick;
        int        t_add;
        int        t_delv;
        int        t_dels;
        int        t_look;
        int        t_clear;
        case (seg)
            SEG_FILL:  begin t_add = 80; t_delv = 85; t_dels = 90; t_look = 98; t_clear = 98; end
            SEG_MIXED: begin t_add = 40; t_delv = 60; t_dels = 75; t_look = 93; t_clear = 96; end
            default:   begin t_add = 15; t_delv = 50; t_dels = 80; t_look = 95; t_clear = 97; end
        endcase
        pick          = $urandom_range(0, 99);
        r.tag_code    = pick_known_code();
        r.slot_number = $urandom_range(0, 31);
        if (pick < t_add)
        begin
            r.op = OP_ADD;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                r.tag_code = '0;
            else if (pick >= 25 || added_codes.size() == 0)
                r.tag_code = $urandom;
        end
        else if (pick < t_delv)
            r.op = OP_DEL_VAL;
        else if (pick < t_dels)
            r.op = OP_DEL_SLOT;
        else if (pick < t_look)
            r.op = OP_LOOKUP;
        else if (pick < t_clear)
            r.op = OP_CLEAR;
        else
            r.op = OP_LOOKUP + 3'($urandom_range(1, 3));
        return r;
    endfunction

    task automatic send_req(req_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        requests_sent++;
        if (item.op == OP_ADD && item.tag_code != '0)
        begin
            added_codes.push_back(item.tag_code);
            if (added_codes.size() > 64)
                void'(added_codes.pop_front());
        end
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        req_item_t item;
        rst_n          <= 1'b0;
        req_valid      <= 1'b0;
        req            <= '0;
        send_idle_pct  = 17;
        recv_idle_pct  = 68;
        hold_request   = 1'b0;
        requests_sent  = 0;

        directed_reqs.push_back(make_req(OP_CLEAR,    32'h0000_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_LOOKUP,   32'h0000_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_DEL_VAL,  32'h0000_0000, 5'd31));
        directed_reqs.push_back(make_req(OP_ADD,      32'h0000_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_ADD,      32'hFFFF_FFFF, 5'd31));
        directed_reqs.push_back(make_req(OP_ADD,      32'h0000_0001, 5'd0));
        directed_reqs.push_back(make_req(OP_ADD,      32'h8000_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_ADD,      32'h0000_0001, 5'd0));
        directed_reqs.push_back(make_req(OP_LOOKUP,   32'h8000_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_LOOKUP,   32'h1234_5678, 5'd0));
        directed_reqs.push_back(make_req(OP_DEL_VAL,  32'h1234_5678, 5'd0));
        directed_reqs.push_back(make_req(OP_DEL_VAL,  32'hFFFF_FFFF, 5'd0));
        directed_reqs.push_back(make_req(OP_LOOKUP,   32'h0000_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_DEL_SLOT, 32'hFFFF_FFFF, 5'd31));
        directed_reqs.push_back(make_req(OP_ADD,      32'h0000_FFFF, 5'd0));
        directed_reqs.push_back(make_req(OP_ADD,      32'hFFFF_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_DEL_SLOT, 32'h0000_0000, 5'd1));
        directed_reqs.push_back(make_req(OP_DEL_SLOT, 32'h0000_0000, 5'd0));
        directed_reqs.push_back(make_req(OP_LOOKUP + 3'd1, 32'hFFFF_FFFF, 5'd31));
        directed_reqs.push_back(make_req(OP_LOOKUP + 3'd2, 32'h0000_0001, 5'd0));
        directed_reqs.push_back(make_req(OP_LOOKUP + 3'd3, 32'hFFFF_FFFF, 5'd31));
        directed_reqs.push_back(make_req(OP_CLEAR,    32'hFFFF_FFFF, 5'd31));
        directed_reqs.push_back(make_req(OP_LOOKUP,   32'hAAAA_AAAA, 5'd0));
        directed_count = directed_reqs.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_reqs[i])
            send_req(directed_reqs[i]);

        // Segments alternate between filling, mixing and draining the table.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 130)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 17;
            end
            if (n == 270)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;
            end
            case ((n / SEGMENT_LEN) % 3)
                0:       item = random_req(SEG_FILL);
                1:       item = random_req(SEG_MIXED);
                default: item = random_req(SEG_DRAIN);
            endcase
            send_req(item);
        end
        req_valid <= 1'b0;

        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        $display("Run: %0d requests (%0d directed), %0d results checked, all five ops and unused codes.",
                 requests_sent, directed_count, results_checked);
        $display("Table was at capacity on %0d transfers; one %0d-cycle result stall backed up requests.",
                 full_reports, HOLD_CYCLES);
        if (mismatch_count == 0 && pending_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
